// ===== design/lrbk_pkg.sv =====
// Package with shared constants, codes and a helper function for the line-reference background key.
`timescale 1ns / 1ps

package lrbk_pkg;

  // Default largest line, in pixels
  localparam int MAX_WIDTH_DEF = 1024;

  // Pixel and channel widths
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  // Configuration register fields
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int LWIDTH_W    = 11;
  localparam int THRESH_W    = 9;
  localparam int REFCOL_W    = 10;

  // Configuration register reset values
  localparam logic [LWIDTH_W-1:0] LWIDTH_RST = 11'd512;
  localparam logic [THRESH_W-1:0] THRESH_RST = 9'd1;
  localparam logic [REFCOL_W-1:0] REFCOL_RST = 10'd0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH = 2'd0,
    REG_THRESHOLD  = 2'd1,
    REG_REF_COLUMN = 2'd2
  } reg_idx_t;

  // Input command codes carried on tuser
  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // True when |a - b| lies strictly below the threshold
  function automatic logic chan_close(input logic [CH_W-1:0] a,
                                      input logic [CH_W-1:0] b,
                                      input logic [THRESH_W-1:0] thr);
    logic [CH_W-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return ({1'b0, diff} < thr);
  endfunction

endpackage

// ===== design/line_reference_background_key_top.sv =====
// Top level of the line-reference background key: line store, control and result stage.
`timescale 1ns / 1ps

//  channel | direction | handshake               | payload
//  in_     | slave     | in_tvalid / in_tready   | in_tdata (pixel), in_tuser (command)
//  out_    | master    | out_tvalid / out_tready | out_tdata (pixel), out_tlast (line end)
//  cfg_    | slave     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One transaction is taken per clock while in_tready is high; a result passes from the
//  line store into the read stage at the edge that accepts the transaction causing it,
//  then into the result register that drives out_tvalid when that register is free.
//  The line store has one write port and two read ports, so pixel writes, pixel
//  reads and the reference read all run in the same cycle.
//  Reset (rst_n low at a clock edge) clears the line position, bank and pending line
//  state and loads register defaults; no pass over the store is needed.
//  A stall on out_tready holds the result register and the read stage, and in_tready
//  drops only when both are full.

module line_reference_background_key_top #(
  parameter int MAX_WIDTH = lrbk_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lrbk_pkg::PIX_W-1:0]      in_tdata,   // red_in, green_in, blue_in
  input  logic                            in_tuser,   // command
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lrbk_pkg::PIX_W-1:0]      out_tdata,  // red_out, green_out, blue_out
  output logic                            out_tlast,  // last_in_line
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrbk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrbk_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W = COL_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int CH_W   = lrbk_pkg::CH_W;
  localparam int PIX_W  = lrbk_pkg::PIX_W;

  // configuration registers
  logic [lrbk_pkg::LWIDTH_W-1:0] lwidth_r;
  logic [lrbk_pkg::THRESH_W-1:0] thresh_r;
  logic [lrbk_pkg::REFCOL_W-1:0] refcol_r;

  // line position state
  logic [COL_W-1:0] wr_col_r, wr_col_nxt;
  logic [CNT_W-1:0] rd_col_r, rd_col_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             bank_r, bank_nxt;

  // read stage
  logic             s1_v_r;
  logic             s1_emit_r, s1_last_r, s1_done_r, s1_byp_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [PIX_W-1:0] rd_pix_r, rd_ref_r;
  logic [PIX_W-1:0] pend_ref_r;

  // result register
  logic             out_tvalid_r, out_tlast_r;
  logic [PIX_W-1:0] out_tdata_r;

  // line store
  logic [PIX_W-1:0] mem [DEPTH];

  // handshake and control
  logic              in_acc, out_free, s1_adv, is_pixel;
  logic              emit, last, line_done, byp;
  logic [CNT_W-1:0]  w_eff, wc1;
  logic [COL_W-1:0]  rc_cl;
  logic [31:0]       lw32, rc32, w32;
  logic [ADDR_W-1:0] wr_addr, rd_addr, ref_addr;
  logic              match;
  logic [PIX_W-1:0]  ref_new;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;
  assign s1_adv    = s1_v_r && out_free;
  assign in_tready = !s1_v_r || out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign is_pixel  = (in_tuser == lrbk_pkg::CMD_PIXEL);

  // Effective width and clamped reference column
  always_comb begin
    lw32 = 32'(lwidth_r);
    if (lw32 == 32'd0) begin
      w32 = 32'd1;
    end else if (lw32 > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end else begin
      w32 = lw32;
    end
    w_eff = CNT_W'(w32);
    rc32  = 32'(refcol_r);
    rc_cl = (rc32 > w32 - 32'd1) ? COL_W'(w32 - 32'd1) : COL_W'(rc32);
  end

  // Next line position: emit one pending pixel, then store an arriving pixel
  always_comb begin
    wr_col_nxt = wr_col_r;
    rd_col_nxt = rd_col_r;
    pend_v_nxt = pend_v_r;
    bank_nxt   = bank_r;
    emit       = pend_v_r && (rd_col_r < w_eff);
    last       = (rd_col_r == w_eff - CNT_W'(1));
    wc1        = CNT_W'(wr_col_r) + CNT_W'(1);
    line_done  = is_pixel && (wc1 >= w_eff);
    byp        = (rc_cl == wr_col_r);
    rd_addr    = {~bank_r, rd_col_r[COL_W-1:0]};
    wr_addr    = {bank_r, wr_col_r};
    ref_addr   = {bank_r, rc_cl};
    if (!emit) begin
      pend_v_nxt = 1'b0;
    end else begin
      rd_col_nxt = rd_col_r + CNT_W'(1);
      if (rd_col_r + CNT_W'(1) >= w_eff) begin
        pend_v_nxt = 1'b0;
      end
    end
    if (is_pixel) begin
      if (line_done) begin
        wr_col_nxt = '0;
        rd_col_nxt = '0;
        pend_v_nxt = 1'b1;
        bank_nxt   = ~bank_r;
      end else begin
        wr_col_nxt = wc1[COL_W-1:0];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lwidth_r <= lrbk_pkg::LWIDTH_RST;
      thresh_r <= lrbk_pkg::THRESH_RST;
      refcol_r <= lrbk_pkg::REFCOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrbk_pkg::REG_LINE_WIDTH: lwidth_r <= cfg_data[lrbk_pkg::LWIDTH_W-1:0];
        lrbk_pkg::REG_THRESHOLD:  thresh_r <= cfg_data[lrbk_pkg::THRESH_W-1:0];
        lrbk_pkg::REG_REF_COLUMN: refcol_r <= cfg_data[lrbk_pkg::REFCOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Line position state, advanced per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_col_r <= '0;
      rd_col_r <= '0;
      pend_v_r <= 1'b0;
      bank_r   <= 1'b0;
    end else if (in_acc) begin
      wr_col_r <= wr_col_nxt;
      rd_col_r <= rd_col_nxt;
      pend_v_r <= pend_v_nxt;
      bank_r   <= bank_nxt;
    end
  end

  // Line store: pixel write, pending pixel read, reference read
  always_ff @(posedge clk) begin
    if (in_acc && is_pixel) begin
      mem[wr_addr] <= in_tdata;
    end
    if (in_acc && emit) begin
      rd_pix_r <= mem[rd_addr];
    end
    if (in_acc && line_done) begin
      rd_ref_r <= mem[ref_addr];
    end
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_acc;
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_emit_r <= emit;
      s1_last_r <= last;
      s1_done_r <= line_done;
      s1_byp_r  <= byp;
      s1_px_r   <= in_tdata;
    end
  end

  // Commit the new line's reference once this transaction's own pixel is out
  assign ref_new = s1_byp_r ? s1_px_r : rd_ref_r;

  always_ff @(posedge clk) begin
    if (s1_adv && s1_done_r) begin
      pend_ref_r <= ref_new;
    end
  end

  // Background match against the pending reference
  assign match = lrbk_pkg::chan_close(rd_pix_r[CH_W-1:0], pend_ref_r[CH_W-1:0], thresh_r) &&
                 lrbk_pkg::chan_close(rd_pix_r[2*CH_W-1:CH_W], pend_ref_r[2*CH_W-1:CH_W],
                                      thresh_r) &&
                 lrbk_pkg::chan_close(rd_pix_r[PIX_W-1:2*CH_W], pend_ref_r[PIX_W-1:2*CH_W],
                                      thresh_r);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_free) begin
      out_tvalid_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tdata_r <= match ? '0 : rd_pix_r;
      out_tlast_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // A flush never moves the write side
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_pixel) |=> ($stable(wr_col_r) && $stable(bank_r)))
    else $error("flush changed the write position or bank");

  // A finished line becomes pending from its first column
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && line_done) |=> (pend_v_r && rd_col_r == '0))
    else $error("completed line not made pending");

  // No result without a pending line
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !pend_v_r) |=> !s1_emit_r)
    else $error("result staged with no pending line");

  // Reference bypass flag is staged when the written column is the reference column
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && line_done && byp) |=> (s1_px_r == rd_ref_r || s1_byp_r))
    else $error("reference bypass flag lost");

endmodule

// ===== test/tb_line_reference_background_key_top.sv =====
// Testbench for the line-reference background key: pixel streams checked against a predictor.
`timescale 1ns / 1ps

module tb_line_reference_background_key_top;

  localparam int LINE_MAX      = lrbk_pkg::MAX_WIDTH_DEF;
  localparam int CH_W          = lrbk_pkg::CH_W;
  localparam int PIX_W         = lrbk_pkg::PIX_W;
  localparam int TOTAL_ITEMS   = 1750;
  localparam int MAX_DRAIN     = 32;
  localparam int SETTLE_CYCLES = 8;

  // Pixel as carried on tdata: red in the lowest byte
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic last;
    rgb_t pix;
  } keyed_px_t;

  typedef enum {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [PIX_W-1:0] in_tdata   = '0;
  logic             in_tuser   = lrbk_pkg::CMD_PIXEL;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [PIX_W-1:0] out_tdata;
  logic             out_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lrbk_pkg::CFG_IDX_W-1:0]  cfg_index = lrbk_pkg::REG_LINE_WIDTH;
  logic [lrbk_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  line_reference_background_key_top #(.MAX_WIDTH(LINE_MAX)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // red_in, green_in, blue_in
    .in_tuser   (in_tuser),   // command
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // red_out, green_out, blue_out
    .out_tlast  (out_tlast),  // last_in_line
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: registers, two-bank line store and line position
  logic [lrbk_pkg::LWIDTH_W-1:0] lw_reg     = lrbk_pkg::LWIDTH_RST;
  logic [lrbk_pkg::THRESH_W-1:0] thr_reg    = lrbk_pkg::THRESH_RST;
  logic [lrbk_pkg::REFCOL_W-1:0] refcol_reg = lrbk_pkg::REFCOL_RST;
  rgb_t line_mem    [0:2*LINE_MAX-1];
  bit   mem_written [0:2*LINE_MAX-1];
  int   wr_col     = 0;
  int   rd_col     = 0;
  bit   pend_valid = 1'b0;
  bit   fill_bank  = 1'b0;
  rgb_t pend_ref   = '0;
  keyed_px_t expected_px[$];

  // Run bookkeeping
  int err_count     = 0;
  int sent_count    = 0;
  int flush_count   = 0;
  int checked_count = 0;
  int black_count   = 0;
  int cfg_count     = 0;
  int burst_left    = 0;
  bit steady_send   = 1'b0;

  // Receiver pattern state
  int       hold_request = 0;
  int       hold_left    = 0;
  int       longest_hold = 0;
  int       mode_left    = 0;
  rx_mode_t rx_mode      = RX_ALWAYS;

  function automatic int active_width();
    if (lw_reg < 1) return 1;
    if (lw_reg > LINE_MAX) return LINE_MAX;
    return int'(lw_reg);
  endfunction

  function automatic bit near_ref(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    int diff;
    diff = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return diff < int'(thr_reg);
  endfunction

  // Queue one pixel of the pending line, keyed to black when it matches its reference
  function automatic void emit_pending();
    int        w;
    keyed_px_t res;
    w = active_width();
    if (!pend_valid || rd_col >= w) begin
      pend_valid = 1'b0;
      return;
    end
    res.pix = line_mem[(fill_bank ? 0 : LINE_MAX) + rd_col];
    if (near_ref(res.pix.red, pend_ref.red) && near_ref(res.pix.green, pend_ref.green) &&
        near_ref(res.pix.blue, pend_ref.blue)) begin
      res.pix = '0;
      black_count++;
    end
    res.last = (rd_col == w - 1);
    expected_px.push_back(res);
    rd_col++;
    if (rd_col >= w) pend_valid = 1'b0;
  endfunction

  // Advance the predictor by one accepted transaction
  function automatic void predict_item(lrbk_pkg::cmd_t cmd, rgb_t px);
    int w;
    int rc;
    emit_pending();
    if (cmd == lrbk_pkg::CMD_FLUSH) return;
    w = active_width();
    line_mem[(fill_bank ? LINE_MAX : 0) + wr_col]    = px;
    mem_written[(fill_bank ? LINE_MAX : 0) + wr_col] = 1'b1;
    wr_col++;
    if (wr_col >= w) begin
      rc         = (int'(refcol_reg) > w - 1) ? w - 1 : int'(refcol_reg);
      pend_ref   = line_mem[(fill_bank ? LINE_MAX : 0) + rc];
      fill_bank  = ~fill_bank;
      wr_col     = 0;
      rd_col     = 0;
      pend_valid = 1'b1;
    end
  endfunction

  function automatic rgb_t mk_rgb(int r, int g, int b);
    rgb_t p;
    p.red   = CH_W'(r);
    p.green = CH_W'(g);
    p.blue  = CH_W'(b);
    return p;
  endfunction

  function automatic rgb_t rand_rgb();
    return rgb_t'(PIX_W'($urandom()));
  endfunction

  function automatic logic [CH_W-1:0] near_channel(logic [CH_W-1:0] base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CH_W'(v);
  endfunction

  // Mostly background-like pixels, the rest fully random
  function automatic rgb_t pick_pixel(rgb_t bg, int spread);
    rgb_t p;
    if ($urandom_range(0, 9) < 6) begin
      p.red   = near_channel(bg.red, spread);
      p.green = near_channel(bg.green, spread);
      p.blue  = near_channel(bg.blue, spread);
    end else begin
      p = rand_rgb();
    end
    return p;
  endfunction

  // Offer one transaction in bursts with random gaps (none in steady sending); predict it once accepted
  task automatic send_item(lrbk_pkg::cmd_t cmd, rgb_t px);
    if (burst_left == 0) begin
      if (!steady_send) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    predict_item(cmd, px);
    burst_left--;
    sent_count++;
    if (cmd == lrbk_pkg::CMD_FLUSH) flush_count++;
  endtask

  // Drop valid and wait until every expected result has come, plus pipeline drain
  task automatic settle();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lrbk_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[lrbk_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lrbk_pkg::REG_LINE_WIDTH: lw_reg     = value[lrbk_pkg::LWIDTH_W-1:0];
      lrbk_pkg::REG_THRESHOLD:  thr_reg    = value[lrbk_pkg::THRESH_W-1:0];
      default:                  refcol_reg = value[lrbk_pkg::REFCOL_W-1:0];
    endcase
    cfg_count++;
    @(posedge clk);
  endtask

  // Change the width; drain first if a wider pending line would read never-written columns
  task automatic set_line_width(logic [31:0] value);
    int neww;
    int c;
    bit unsafe;
    neww   = (value[lrbk_pkg::LWIDTH_W-1:0] < 1) ? 1 :
             (value[lrbk_pkg::LWIDTH_W-1:0] > LINE_MAX) ? LINE_MAX :
             int'(value[lrbk_pkg::LWIDTH_W-1:0]);
    unsafe = 1'b0;
    if (pend_valid)
      for (c = rd_col; c < neww; c++)
        if (!mem_written[(fill_bank ? 0 : LINE_MAX) + c]) unsafe = 1'b1;
    if (unsafe) begin
      while (pend_valid) send_item(lrbk_pkg::CMD_FLUSH, '0);
      settle();
    end
    write_reg(lrbk_pkg::REG_LINE_WIDTH, value);
  endtask

  // Nothing pending after reset: flush and pixels give no result
  task automatic test_reset_state();
    send_item(lrbk_pkg::CMD_FLUSH, mk_rgb(255, 255, 255));
    send_item(lrbk_pkg::CMD_PIXEL, mk_rgb(0, 0, 0));
    send_item(lrbk_pkg::CMD_PIXEL, mk_rgb(255, 255, 255));
  endtask

  // Shrink the width mid-line, then grow it again while that line is pending
  task automatic test_width_changes();
    settle();
    set_line_width(1);
    send_item(lrbk_pkg::CMD_PIXEL, mk_rgb(8'h12, 8'h34, 8'h56));
    settle();
    set_line_width(3);
    repeat (3) send_item(lrbk_pkg::CMD_FLUSH, '0);
  endtask

  // Pending line dropped when a shrunk width ends the next line at once
  task automatic test_line_cut_short();
    settle();
    repeat (3) send_item(lrbk_pkg::CMD_PIXEL, rand_rgb());
    send_item(lrbk_pkg::CMD_PIXEL, rand_rgb());
    settle();
    set_line_width(0);
    send_item(lrbk_pkg::CMD_PIXEL, rand_rgb());
    send_item(lrbk_pkg::CMD_FLUSH, '0);
  endtask

  // Threshold boundary on both signs, clamped reference column, threshold extremes
  task automatic test_threshold_edges();
    settle();
    set_line_width(4);
    write_reg(lrbk_pkg::REG_REF_COLUMN, 1023);
    write_reg(lrbk_pkg::REG_THRESHOLD, 5);
    send_item(lrbk_pkg::CMD_PIXEL, mk_rgb(104, 146, 200));
    send_item(lrbk_pkg::CMD_PIXEL, mk_rgb(105, 150, 200));
    send_item(lrbk_pkg::CMD_PIXEL, mk_rgb(100, 150, 195));
    send_item(lrbk_pkg::CMD_PIXEL, mk_rgb(100, 150, 200));
    repeat (4) send_item(lrbk_pkg::CMD_FLUSH, '0);
    settle();
    set_line_width(2);
    write_reg(lrbk_pkg::REG_REF_COLUMN, 0);
    send_item(lrbk_pkg::CMD_PIXEL, mk_rgb(0, 0, 0));
    send_item(lrbk_pkg::CMD_PIXEL, mk_rgb(255, 255, 255));
    settle();
    write_reg(lrbk_pkg::REG_THRESHOLD, 256);
    send_item(lrbk_pkg::CMD_FLUSH, '0);
    settle();
    write_reg(lrbk_pkg::REG_THRESHOLD, 255);
    send_item(lrbk_pkg::CMD_FLUSH, '0);
    settle();
    write_reg(lrbk_pkg::REG_THRESHOLD, 0);
    send_item(lrbk_pkg::CMD_PIXEL, mk_rgb(7, 7, 7));
    send_item(lrbk_pkg::CMD_PIXEL, mk_rgb(7, 7, 8));
    repeat (2) send_item(lrbk_pkg::CMD_FLUSH, '0);
  endtask

  // One full line at the widest setting, reference at the far end; drain its head
  task automatic test_max_width();
    rgb_t bg;
    settle();
    set_line_width(2047);
    write_reg(lrbk_pkg::REG_REF_COLUMN, 1023);
    write_reg(lrbk_pkg::REG_THRESHOLD, $urandom_range(2, 30));
    bg = rand_rgb();
    repeat (LINE_MAX - 1) send_item(lrbk_pkg::CMD_PIXEL, pick_pixel(bg, 20));
    send_item(lrbk_pkg::CMD_PIXEL, bg);
    repeat (MAX_DRAIN) send_item(lrbk_pkg::CMD_FLUSH, '0);
  endtask

  // Hold off the receiver for a long stretch while pixels keep coming
  task automatic test_backpressure();
    rgb_t bg;
    settle();
    set_line_width(4);
    write_reg(lrbk_pkg::REG_THRESHOLD, 12);
    bg = rand_rgb();
    repeat (4) send_item(lrbk_pkg::CMD_PIXEL, pick_pixel(bg, 10));
    hold_request = 80;
    steady_send  = 1'b1;
    repeat (40) send_item(lrbk_pkg::CMD_PIXEL, pick_pixel(bg, 10));
    steady_send  = 1'b0;
  endtask

  // Random settings per phase, then mostly well-formed lines with some flushes
  task automatic test_random_lines();
    int             spread;
    logic [31:0]    value;
    rgb_t           bg;
    lrbk_pkg::cmd_t cmd;
    while (sent_count < TOTAL_ITEMS) begin
      settle();
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       value = 0;
          1:       value = 1;
          2:       value = $urandom_range(13, 64);
          default: value = $urandom_range(2, 12);
        endcase
        set_line_width(value);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       value = 0;
          1:       value = 1;
          2:       value = 255;
          3:       value = 256;
          4:       value = 511;
          default: value = $urandom_range(2, 48);
        endcase
        write_reg(lrbk_pkg::REG_THRESHOLD, value);
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       value = 0;
          1:       value = 1023;
          2:       value = $urandom_range(0, 15);
          default: value = $urandom_range(0, 1023);
        endcase
        write_reg(lrbk_pkg::REG_REF_COLUMN, value);
      end
      bg     = rand_rgb();
      spread = $urandom_range(0, 12);
      repeat ($urandom_range(4, 60)) begin
        cmd = ($urandom_range(0, 9) == 0) ? lrbk_pkg::CMD_FLUSH : lrbk_pkg::CMD_PIXEL;
        send_item(cmd, pick_pixel(bg, spread));
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 8)) send_item(lrbk_pkg::CMD_FLUSH, rand_rgb());
    end
  endtask

  // Receiver: switch between stall patterns, honor long hold requests
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
      if (hold_left > longest_hold) longest_hold = hold_left;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(30, 300);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Compare each result transaction with the oldest expectation
  keyed_px_t exp_head;
  rgb_t      got_px;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_px = out_tdata;
      if (expected_px.size() == 0) begin
        $error("unexpected result: tdata %h tlast %b", out_tdata, out_tlast);
        err_count++;
      end else begin
        exp_head = expected_px.pop_front();
        checked_count++;
        if (got_px.red !== exp_head.pix.red) begin
          $error("red_out: expected %0d, got %0d", exp_head.pix.red, got_px.red);
          err_count++;
        end
        if (got_px.green !== exp_head.pix.green) begin
          $error("green_out: expected %0d, got %0d", exp_head.pix.green, got_px.green);
          err_count++;
        end
        if (got_px.blue !== exp_head.pix.blue) begin
          $error("blue_out: expected %0d, got %0d", exp_head.pix.blue, got_px.blue);
          err_count++;
        end
        if (out_tlast !== exp_head.last) begin
          $error("last_in_line: expected %0b, got %0b", exp_head.last, out_tlast);
          err_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_width_changes();
    test_line_cut_short();
    test_threshold_edges();
    test_max_width();
    test_backpressure();
    test_random_lines();
    settle();
    $display("covered %0d input transactions (%0d flushes), %0d results checked, %0d black",
             sent_count, flush_count, checked_count, black_count);
    $display("made %0d register writes; longest receiver hold %0d cycles",
             cfg_count, longest_hold);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("stopped early after %0d input transactions, %0d results checked",
             sent_count, checked_count);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
design/lrbk_pkg.sv
design/line_reference_background_key_top.sv
test/tb_line_reference_background_key_top.sv
